>>> design/qsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qsc_pkg: shared types and constants of the QPSK sync word correlator
// Item structs, lane result type, configuration register codes and the
// derivation of the four phase-rotated sync patterns.
// ----------------------------------------------------------------------------
package qsc_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 1024;

  localparam int unsigned WIN_W     = 64;
  localparam int unsigned WIN_BYTES = WIN_W / 8;
  localparam int unsigned NUM_LANES = 8;
  localparam int unsigned NUM_ROT   = 4;
  localparam int unsigned ROT_W     = $clog2(NUM_ROT);
  localparam int unsigned SCORE_W   = 7;
  localparam int unsigned POS_W     = 13;
  localparam int unsigned CNT_W     = 11;
  localparam int unsigned BASE_W    = CNT_W + $clog2(NUM_LANES);
  localparam int unsigned EXT_W     = WIN_W + NUM_LANES;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam int unsigned POS_BOUND_RAW = (MAX_FRAME_BYTES - WIN_BYTES) * 8 - 1;
  localparam int unsigned POS_HARD_MAX  = (1 << POS_W) - 1;
  localparam int unsigned POS_BOUND_INT =
    (POS_BOUND_RAW > POS_HARD_MAX) ? POS_HARD_MAX : POS_BOUND_RAW;
  localparam logic [BASE_W-1:0] POS_BOUND = BASE_W'(POS_BOUND_INT);

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [WIN_W-1:0] ODD_MASK  = 64'h5555_5555_5555_5555;
  localparam logic [WIN_W-1:0] EVEN_MASK = 64'hAAAA_AAAA_AAAA_AAAA;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_PATTERN    = 4'd0,
    CFG_MATCH_THRESHOLD = 4'd1
  } cfg_reg_e;

  // What a byte does to the frame: fill the window, run the offset-zero
  // check, or score eight bit positions.
  typedef enum logic [1:0] {
    MODE_FILL  = 2'd0,
    MODE_CHECK = 2'd1,
    MODE_SCORE = 2'd2
  } mode_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] sync_offset;
    logic [ROT_W-1:0] sync_phase;
  } out_item_t;

  typedef struct packed {
    mode_e             mode;
    logic              last;
    logic [BASE_W-1:0] base;
  } ctl_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [ROT_W-1:0]   rot;
  } lane_res_t;

  typedef logic [NUM_ROT-1:0][WIN_W-1:0] pat_arr_t;

  function automatic logic [WIN_W-1:0] swap_pairs(input logic [WIN_W-1:0] w);
    return ((w & ODD_MASK) << 1) | ((w & EVEN_MASK) >> 1);
  endfunction

  function automatic pat_arr_t derive_patterns(input logic [WIN_W-1:0] p);
    logic [WIN_W-1:0] hi;
    logic [WIN_W-1:0] lo;
    pat_arr_t         res;
    hi     = p & EVEN_MASK;
    lo     = p & ODD_MASK;
    res[0] = swap_pairs(p);
    res[1] = swap_pairs(((hi ^ EVEN_MASK) >> 1) | (lo << 1));
    res[2] = swap_pairs(~p);
    res[3] = swap_pairs((hi >> 1) | ((lo ^ ODD_MASK) << 1));
    return res;
  endfunction

endpackage
`default_nettype wire

>>> design/qpsk_syncword_correlator.sv
// The last byte of a frame passes stages s1, s2 and s3; then its result is registered.
// Throughput: one byte per cycle unless a stalled result holds a frame end; eight lanes
// of four 64-bit popcounts score all eight bit positions of a byte at once.
// Reset: the pipeline empties, sync_pattern returns to 0 and match_threshold
// to 48; no clearing pass, the block takes bytes as soon as reset is released.
`default_nettype none
// ----------------------------------------------------------------------------
// qpsk_syncword_correlator: QPSK sync word correlator, top level
// Byte window, configuration registers and pipeline control around the
// eight correlation lanes and the merge stage.
// ----------------------------------------------------------------------------
module qpsk_syncword_correlator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  qsc_pkg::in_item_t                in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output qsc_pkg::out_item_t               out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [qsc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [qsc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import qsc_pkg::*;

  logic [WIN_W-1:0]   sync_pattern_q;
  logic [SCORE_W-1:0] threshold_q;
  pat_arr_t           patterns;

  logic [WIN_W-1:0]   win_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               accept;
  mode_e              in_mode;
  ctl_t               in_ctl;

  logic               s1_v_q, s2_v_q, s3_v_q;
  logic [EXT_W-1:0]   s1_ext_q;
  ctl_t               s1_ctl_q, s2_ctl_q, s3_ctl_q;
  logic               s2_free, s3_free, s3_take, out_free;

  logic [NUM_LANES-1:0][WIN_W-1:0] lane_win;
  lane_res_t [NUM_LANES-1:0]       lane_best;
  logic [NUM_LANES-1:0][NUM_ROT-1:0] lane_hit;
  logic [NUM_LANES-1:0][POS_W-1:0] pos_d, s3_pos_q;

  // ---------------- configuration ----------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_pattern_q <= '0;
      threshold_q    <= SCORE_W'(48);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_SYNC_PATTERN:    sync_pattern_q <= cfg_data_i[WIN_W-1:0];
        CFG_MATCH_THRESHOLD: threshold_q    <= cfg_data_i[SCORE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign patterns = derive_patterns(sync_pattern_q);

  // ---------------- pipeline control ----------------
  assign s3_take    = s3_v_q && (!s3_ctl_q.last || out_free);
  assign s3_free    = !s3_v_q || s3_take;
  assign s2_free    = !s2_v_q || (s2_v_q && s3_free);
  assign in_ready_o = !s1_v_q || (s1_v_q && s2_free);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    if (cnt_q < CNT_W'(WIN_BYTES - 1)) begin
      in_mode = MODE_FILL;
    end else if (cnt_q == CNT_W'(WIN_BYTES - 1)) begin
      in_mode = MODE_CHECK;
    end else begin
      in_mode = MODE_SCORE;
    end
    in_ctl.mode = in_mode;
    in_ctl.last = in_data_i.last_byte;
    in_ctl.base = (in_mode == MODE_SCORE) ?
                  {cnt_q - CNT_W'(WIN_BYTES), 3'b000} : '0;
  end

  // Frame front end: shift the window a byte per transfer, count bytes, clear both on the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      cnt_q <= '0;
    end else if (accept) begin
      if (in_data_i.last_byte) begin
        win_q <= '0;
        cnt_q <= '0;
      end else begin
        win_q <= {win_q[WIN_W-9:0], in_data_i.data_byte};
        if (cnt_q != CNT_MAX) cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_v_q <= in_valid_i;
      if (s2_free)    s2_v_q <= s1_v_q;
      if (s3_free)    s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      s1_ext_q <= {win_q, in_data_i.data_byte};
      s1_ctl_q <= in_ctl;
    end
    if (s2_free) s2_ctl_q <= s1_ctl_q;
    if (s3_free) begin
      s3_ctl_q <= s2_ctl_q;
      s3_pos_q <= pos_d;
    end
  end

  // Lane j sees the window before bit j shifts in; the offset-zero check
  // looks at the full window after the eighth byte, on lane 0.
  always_comb begin
    for (int j = 0; j < NUM_LANES; j++) begin
      lane_win[j] = s1_ext_q[EXT_W-1-j -: WIN_W];
    end
    if (s1_ctl_q.mode == MODE_CHECK) lane_win[0] = s1_ext_q[WIN_W-1:0];
  end

  always_comb begin
    logic [BASE_W-1:0] p;
    for (int j = 0; j < NUM_LANES; j++) begin
      p        = s2_ctl_q.base + BASE_W'(j);
      pos_d[j] = (p > POS_BOUND) ? POS_W'(POS_BOUND) : POS_W'(p);
    end
  end

  for (genvar j = 0; j < NUM_LANES; j++) begin : g_lane
    qsc_lane u_lane (
      .clk_i       (clk_i),
      .score_en_i  (s2_free),
      .best_en_i   (s3_free),
      .window_i    (lane_win[j]),
      .patterns_i  (patterns),
      .threshold_i (threshold_q),
      .best_o      (lane_best[j]),
      .hit_o       (lane_hit[j])
    );
  end

  qsc_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (s3_take),
    .ctl_i       (s3_ctl_q),
    .lane_i      (lane_best),
    .pos_i       (s3_pos_q),
    .hit_i       (lane_hit[0]),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_free_o  (out_free)
  );

endmodule
`default_nettype wire

>>> design/qsc_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qsc_lane: correlation lane for one bit position
// Scores one 64-bit window against all four rotated patterns, then picks
// the best rotation and flags the rotations above the threshold.
// ----------------------------------------------------------------------------
module qsc_lane (
  input  logic                          clk_i,
  input  logic                          score_en_i,
  input  logic                          best_en_i,
  input  logic [qsc_pkg::WIN_W-1:0]     window_i,
  input  qsc_pkg::pat_arr_t             patterns_i,
  input  logic [qsc_pkg::SCORE_W-1:0]   threshold_i,
  output qsc_pkg::lane_res_t            best_o,
  output logic [qsc_pkg::NUM_ROT-1:0]   hit_o
);
  import qsc_pkg::*;

  // 64 minus the Hamming distance, as an adder tree
  function automatic logic [SCORE_W-1:0] match_count(input logic [WIN_W-1:0] a,
                                                     input logic [WIN_W-1:0] b);
    logic [WIN_W-1:0] d;
    logic [1:0]       l1 [32];
    logic [2:0]       l2 [16];
    logic [3:0]       l3 [8];
    logic [4:0]       l4 [4];
    logic [5:0]       l5 [2];
    logic [6:0]       l6;
    d = a ^ b;
    for (int i = 0; i < 32; i++) l1[i] = {1'b0, d[2*i]} + {1'b0, d[2*i+1]};
    for (int i = 0; i < 16; i++) l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    for (int i = 0; i < 8; i++)  l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    for (int i = 0; i < 4; i++)  l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
    for (int i = 0; i < 2; i++)  l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
    l6 = {1'b0, l5[0]} + {1'b0, l5[1]};
    return SCORE_W'(WIN_W) - l6;
  endfunction

  logic [NUM_ROT-1:0][SCORE_W-1:0] score_q;
  lane_res_t                       best_d, best_q;
  logic [NUM_ROT-1:0]              hit_d, hit_q;

  always_ff @(posedge clk_i) begin
    if (score_en_i) begin
      for (int r = 0; r < NUM_ROT; r++) begin
        score_q[r] <= match_count(patterns_i[r], window_i);
      end
    end
  end

  // Lowest rotation keeps a tie
  always_comb begin
    best_d.score = score_q[0];
    best_d.rot   = '0;
    for (int r = 1; r < NUM_ROT; r++) begin
      if (score_q[r] > best_d.score) begin
        best_d.score = score_q[r];
        best_d.rot   = ROT_W'(r);
      end
    end
    for (int r = 0; r < NUM_ROT; r++) begin
      hit_d[r] = score_q[r] > threshold_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (best_en_i) begin
      best_q <= best_d;
      hit_q  <= hit_d;
    end
  end

  assign best_o = best_q;
  assign hit_o  = hit_q;

endmodule
`default_nettype wire

>>> design/qsc_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qsc_merge: lane merge and frame result
// Reduces the eight lane results of a byte, keeps the running best match
// or the offset-zero hit, and holds the result register.
// ----------------------------------------------------------------------------
module qsc_merge (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           take_i,
  input  qsc_pkg::ctl_t                                  ctl_i,
  input  qsc_pkg::lane_res_t [qsc_pkg::NUM_LANES-1:0]    lane_i,
  input  logic [qsc_pkg::NUM_LANES-1:0][qsc_pkg::POS_W-1:0] pos_i,
  input  logic [qsc_pkg::NUM_ROT-1:0]                    hit_i,
  input  logic                                           out_ready_i,
  output logic                                           out_valid_o,
  output qsc_pkg::out_item_t                             out_data_o,
  output logic                                           out_free_o
);
  import qsc_pkg::*;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [ROT_W-1:0]   rot;
    logic [POS_W-1:0]   pos;
  } cand_t;

  // The earlier candidate wins a tie
  function automatic cand_t pick(input cand_t a, input cand_t b);
    return (b.score > a.score) ? b : a;
  endfunction

  cand_t              c0 [NUM_LANES];
  cand_t              c1 [NUM_LANES/2];
  cand_t              c2 [NUM_LANES/4];
  cand_t              top_c;
  logic [ROT_W-1:0]   hit_rot;
  logic               any_hit;

  logic [SCORE_W-1:0] best_score_d, best_score_q;
  logic [POS_W-1:0]   best_pos_d, best_pos_q;
  logic [ROT_W-1:0]   best_rot_d, best_rot_q;
  logic               early_d, early_q;
  logic               out_valid_q;
  out_item_t          out_data_q;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      c0[i] = '{score: lane_i[i].score, rot: lane_i[i].rot, pos: pos_i[i]};
    end
    for (int i = 0; i < NUM_LANES/2; i++) c1[i] = pick(c0[2*i], c0[2*i+1]);
    for (int i = 0; i < NUM_LANES/4; i++) c2[i] = pick(c1[2*i], c1[2*i+1]);
    top_c = pick(c2[0], c2[1]);

    any_hit = |hit_i;
    hit_rot = '0;
    for (int r = NUM_ROT - 1; r >= 0; r--) begin
      if (hit_i[r]) hit_rot = ROT_W'(r);
    end
  end

  always_comb begin
    best_score_d = best_score_q;
    best_pos_d   = best_pos_q;
    best_rot_d   = best_rot_q;
    early_d      = early_q;
    if (!early_q) begin
      unique case (ctl_i.mode)
        MODE_CHECK: begin
          if (any_hit) begin
            early_d    = 1'b1;
            best_pos_d = '0;
            best_rot_d = hit_rot;
          end
        end
        MODE_SCORE: begin
          if (top_c.score > best_score_q) begin
            best_score_d = top_c.score;
            best_pos_d   = top_c.pos;
            best_rot_d   = top_c.rot;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_score_q <= '0;
      best_pos_q   <= '0;
      best_rot_q   <= '0;
      early_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (take_i) begin
        if (ctl_i.last) begin
          // frame done: drop all frame state
          best_score_q <= '0;
          best_pos_q   <= '0;
          best_rot_q   <= '0;
          early_q      <= 1'b0;
        end else begin
          best_score_q <= best_score_d;
          best_pos_q   <= best_pos_d;
          best_rot_q   <= best_rot_d;
          early_q      <= early_d;
        end
      end
      if (take_i && ctl_i.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && ctl_i.last) begin
      out_data_q.sync_offset <= best_pos_d;
      out_data_q.sync_phase  <= best_rot_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_free_o  = !out_valid_q || out_ready_i;

endmodule
`default_nettype wire

>>> design/qsc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qsc_checker: port-level checks of the sync word correlator
// Watches the top-level ports and is bound to the top level below.
// ----------------------------------------------------------------------------
module qsc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input qsc_pkg::out_item_t out_data_o
);
  import qsc_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  a_offset_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, out_data_o.sync_offset} <= POS_BOUND))
    else $error("sync offset beyond its bound");

  // only a stalled result may block input
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input blocked without an output stall");

  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !out_valid_o)
    else $error("result valid straight after reset");

endmodule

bind qpsk_syncword_correlator qsc_checker u_qsc_checker (.*);
`default_nettype wire
